// File: rtl/bitmap_run_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shared property macros for the bitmap run allocator checkers.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BRA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BRA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Request and response types, codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bra_pkg;

    // Field widths
    localparam int TYPE_W   = 2;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 12;

    // Bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;
    localparam int TCNT_W    = 6;

    // Request types
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SET   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_TEST  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_FIND  = 2'd3;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BIT_SET   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [START_W-1:0] start_bit;
        logic [COUNT_W-1:0] bit_count;
        logic [COUNT_W-1:0] run_length;
    } bra_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    run_offset;
    } bra_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic init_wr;
        logic load_req;
        logic scan_first;
        logic scan_step;
        logic load_result;
    } bra_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic init_last;
        logic range_err;
        logic empty;
        logic scan_last;
    } bra_sts_t;

endpackage

// File: rtl/bra_ram.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bra_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator controller
// Sequences the clearing pass, request load, word scan and response hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bra_pkg::bra_cmd_t cmd,
    input  bra_pkg::bra_sts_t sts
);

    import bra_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.load_req = req_valid;
                if (req_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (sts.range_err || sts.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_first = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.load_result = !rsp_valid_reg || rsp_ready;
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Response valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.load_result)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/bra_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator datapath
// Request registers, word masking, read-modify-write and run search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_datapath #(
    parameter int MAP_BITS = 4096,
    localparam int MAP_WORDS = (MAP_BITS + bra_pkg::WORD_BITS - 1) / bra_pkg::WORD_BITS,
    localparam int WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bra_pkg::bra_cmd_t              cmd,
    output bra_pkg::bra_sts_t              sts,
    input  bra_pkg::bra_req_t              req_data,
    output bra_pkg::bra_rsp_t              rsp_data,
    output logic                           mem_wr_en,
    output logic [WA_W-1:0]                mem_wr_addr,
    output logic [bra_pkg::WORD_BITS-1:0]  mem_wr_data,
    output logic                           mem_rd_en,
    output logic [WA_W-1:0]                mem_rd_addr,
    input  logic [bra_pkg::WORD_BITS-1:0]  mem_rd_data
);

    import bra_pkg::*;

    localparam int MB_W  = $clog2(MAP_BITS + 1);
    localparam int SUM_W = (MB_W > START_W + 2) ? MB_W : START_W + 2;
    localparam int LVLS  = WORD_LSB;

    // Request registers
    logic [TYPE_W-1:0]  type_reg;
    logic [SUM_W-1:0]   start_reg;
    logic [SUM_W-1:0]   end_reg;
    logic [COUNT_W-1:0] run_reg;
    logic               range_err_reg;
    logic               empty_reg;

    // Scan state
    logic [WA_W-1:0]     word_reg;
    logic [COUNT_W-1:0]  carry_reg;
    logic [COUNT_W-1:0]  carry_next;
    logic                bitset_reg;
    logic                found_reg;
    logic [WA_W-1:0]     hit_word_reg;
    logic [WORD_LSB-1:0] hit_pos_reg;
    bra_rsp_t            rsp_reg;

    logic [SUM_W-1:0]     start_ext;
    logic [SUM_W-1:0]     sum_ext;
    logic [WA_W-1:0]      first_word;
    logic [WA_W-1:0]      last_word;
    logic [WORD_LSB-1:0]  lo_bit;
    logic [WORD_LSB-1:0]  hi_bit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] bits;
    logic                 is_write;

    // Run search prefix network
    logic [WORD_BITS-1:0] all_ones [LVLS+1];
    logic [TCNT_W-1:0]    trail    [LVLS+1][WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic [COUNT_W-1:0]   thr_pre;
    logic [WORD_LSB-1:0]  hit_pos;
    logic                 hit_any;

    bra_rsp_t             rsp_next;
    logic [SUM_W-1:0]     off_ext;

    // Range decode of the incoming request
    assign start_ext = SUM_W'(req_data.start_bit);
    assign sum_ext   = start_ext + SUM_W'(req_data.bit_count);

    assign first_word = start_reg[WORD_LSB +: WA_W];
    assign last_word  = end_reg[WORD_LSB +: WA_W];

    // In-range bit mask for the current word
    assign lo_bit = (word_reg == first_word) ? start_reg[WORD_LSB-1:0] : '0;
    assign hi_bit = (word_reg == last_word) ? end_reg[WORD_LSB-1:0] : '1;
    assign mask   = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));
    assign bits   = mem_rd_data & mask;

    assign is_write = (type_reg == REQ_CLEAR) || (type_reg == REQ_SET);

    // Memory port drive
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = word_reg;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = word_reg + 1'b1;
        if (cmd.init_wr)
        begin
            mem_wr_en = 1'b1;
        end
        else if (cmd.scan_first)
        begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = first_word;
        end
        else if (cmd.scan_step)
        begin
            mem_rd_en   = !sts.scan_last;
            mem_wr_en   = is_write;
            mem_wr_data = (type_reg == REQ_SET) ? (mem_rd_data | mask)
                                                : (mem_rd_data & ~mask);
        end
    end

    // Trailing-ones count ending at each bit, log-depth prefix
    always_comb
    begin
        all_ones[0] = bits;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            trail[0][j] = TCNT_W'(bits[j]);
        end
        for (int l = 0; l < LVLS; l++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (j >= (1 << l))
                begin
                    all_ones[l+1][j] = all_ones[l][j] & all_ones[l][j - (1 << l)];
                    trail[l+1][j]    = all_ones[l][j] ? trail[l][j] + trail[l][j - (1 << l)]
                                                      : trail[l][j];
                end
                else
                begin
                    all_ones[l+1][j] = all_ones[l][j];
                    trail[l+1][j]    = trail[l][j];
                end
            end
        end
    end

    // Run length reached at each bit, with carry from earlier words
    assign thr_pre = run_reg - carry_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            hit_vec[j] = (run_reg != '0) &&
                         ((COUNT_W'(trail[LVLS][j]) >= run_reg) ||
                          (all_ones[LVLS][j] && (COUNT_W'(trail[LVLS][j]) >= thr_pre)));
        end
    end

    // Lowest matching bit
    always_comb
    begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_pos = WORD_LSB'(j);
            end
        end
    end

    assign hit_any    = |hit_vec;
    assign carry_next = all_ones[LVLS][WORD_BITS-1]
                        ? carry_reg + COUNT_W'(trail[LVLS][WORD_BITS-1])
                        : COUNT_W'(trail[LVLS][WORD_BITS-1]);

    // Status to the controller
    assign sts.init_last = (word_reg == WA_W'(MAP_WORDS - 1));
    assign sts.range_err = range_err_reg;
    assign sts.empty     = empty_reg;
    assign sts.scan_last = (word_reg == last_word);

    // Response assembly
    assign off_ext = SUM_W'({hit_word_reg, hit_pos_reg}) + SUM_W'(1)
                     - SUM_W'(run_reg) - start_reg;

    always_comb
    begin
        rsp_next.run_offset = '0;
        if (range_err_reg)
        begin
            rsp_next.status = ST_RANGE;
        end
        else
        begin
            case (type_reg)
                REQ_TEST:
                begin
                    rsp_next.status = bitset_reg ? ST_BIT_SET : ST_OK;
                end
                REQ_FIND:
                begin
                    rsp_next.status = found_reg ? ST_OK : ST_NOT_FOUND;
                    if (found_reg)
                    begin
                        rsp_next.run_offset = off_ext[OFF_W-1:0];
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            range_err_reg <= 1'b0;
            empty_reg     <= 1'b0;
            bitset_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr)
            begin
                word_reg <= word_reg + 1'b1;
            end
            if (cmd.load_req)
            begin
                range_err_reg <= (sum_ext > SUM_W'(MAP_BITS));
                empty_reg     <= (req_data.bit_count == '0);
                bitset_reg    <= 1'b0;
                found_reg     <= 1'b0;
            end
            if (cmd.scan_first)
            begin
                word_reg <= first_word;
            end
            if (cmd.scan_step)
            begin
                word_reg   <= word_reg + 1'b1;
                bitset_reg <= bitset_reg | (|bits);
                if ((type_reg == REQ_FIND) && hit_any)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg  <= req_data.req_type;
            start_reg <= start_ext;
            end_reg   <= sum_ext - SUM_W'(1);
            run_reg   <= req_data.run_length;
        end
        if (cmd.scan_first)
        begin
            carry_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            carry_reg <= carry_next;
            if ((type_reg == REQ_FIND) && hit_any && !found_reg)
            begin
                hit_word_reg <= word_reg;
                hit_pos_reg  <= hit_pos;
            end
        end
        if (cmd.load_result)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// File: rtl/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator
// One bitmap page with clear, set, test and find-run requests.
// ----------------------------------------------------------------------------
// The map is held as MAP_BITS/32 words of 32 bits in a dual-port RAM and is
// walked one word per cycle through a read-modify-write loop. A request holds
// the block through a setup step, a scan of each 32-bit word that its range
// touches and a done step; a request with a range error or a zero count skips
// the scan. After reset a clearing pass writes zero to every word, with
// req_ready low. A finished response sits in an output register, so a new
// request is taken while the previous response waits.
`timescale 1ns / 1ps

module bitmap_run_allocator #(
    parameter int MAP_BITS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bra_pkg::bra_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bra_pkg::bra_rsp_t rsp_data
);

    import bra_pkg::*;

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    bra_cmd_t             cmd;
    bra_sts_t             sts;
    logic                 mem_wr_en;
    logic [WA_W-1:0]      mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [WA_W-1:0]      mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    // Sequencer
    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Masking, update and run search
    bra_datapath #(
        .MAP_BITS (MAP_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_data    (req_data),
        .rsp_data    (rsp_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Bitmap storage
    bra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// File: rtl/bra_checker.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_run_allocator_defines.svh"

module bra_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input bra_pkg::bra_req_t req_data,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input bra_pkg::bra_rsp_t rsp_data
);

    import bra_pkg::*;

    // A stalled response holds its payload
    `BRA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

    // Only a found run carries a nonzero offset
    `BRA_ASSERT_IMP(a_offset_zero, clk, rst_n, rsp_valid && (rsp_data.status != ST_OK), rsp_data.run_offset == '0, "offset set without a found run")

    // The block works on one request at a time
    `BRA_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // A new response is produced only while no request is being taken
    `BRA_ASSERT_IMP(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(!req_ready), "response without a finished request")

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);
